[rtl/eras_pkg.sv]
// shared types, widths and codes of the extent table address splitter
package eras_pkg;

    // default table geometry
    localparam int DEVICES_DEF          = 16;
    localparam int FILES_PER_DEVICE_DEF = 16;
    localparam int EXTENTS_PER_FILE_DEF = 8;
    localparam int MAX_PIECES_DEF       = 64;

    // field widths
    localparam int BS_W       = 27;
    localparam int CHUNK_W    = 25;
    localparam int MEMB_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int DEV_W      = 4;
    localparam int FILE_W     = 4;
    localparam int ENTRY_W    = 3;
    localparam int ADDR_W     = 48;
    localparam int LEN_W      = 40;
    localparam int TAG_W      = 16;
    localparam int STAT_W     = 3;
    localparam int PLEN_W     = 27;

    // internal widths: physical start sum and stripe width; multiplier split and member cap
    localparam int START_W    = ADDR_W + 1;
    localparam int STRIPE_W   = CHUNK_W + 4;
    localparam int MUL_SPLIT  = 25;
    localparam int MEMB_MAX   = 16;

    // register reset values
    localparam logic [BS_W-1:0]    BLOCK_SIZE_RST = BS_W'(4194304);
    localparam logic [CHUNK_W-1:0] CHUNK_RST      = '0;
    localparam logic [MEMB_W-1:0]  MEMBERS_RST    = MEMB_W'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBERS    = 2'd2;

    // request types
    localparam logic REQ_WRITE     = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PAST_END  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_WRITE_ACK = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ACK,
        EM_NOT_FOUND,
        EM_PAST,
        EM_PIECE
    } t_emit;

    typedef enum logic {
        DIV_ROW,
        DIV_CHUNK
    } t_div_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     clr;
        logic     capture;
        logic     mem_wr;
        logic     rd_scan;
        logic     rd_next;
        logic     k_inc;
        logic     hit_load;
        logic     calc_a;
        logic     calc_b;
        logic     p2_load;
        logic     span2_load;
        logic     width_load;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_row_save;
        logic     div_chunk_save;
        logic     mul_lo;
        logic     mul_hi;
        logic     mul_sum;
        t_emit    emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic is_write;
        logic key_ok;
        logic k_last;
        logic hit;
        logic rem_left;
        logic next_exists;
        logic rd_valid;
        logic striped;
        logic div_busy;
        logic out_free;
        logic piece_final;
        logic piece_more;
    } t_sts;

endpackage

[rtl/extent_raid0_address_splitter_unit.sv]
// Extent table lookup with RAID0 address splitting.
// Input channel i_valid/o_stall carries one transaction: an extent write
// (req_type 0) or a translate (req_type 1). Output channel o_valid/i_stall
// carries result transactions; each run ends with o_last set.
// A write returns one acknowledge.
// A translate scans the file's extent slots in turn through the single read
// port of the extent memory, then sets up the span. Unstriped, each span is
// one piece. Striped, each span first runs two divisions (stripe row, then
// member) on the shared bit-serial divider, then the multiply steps for the
// low half, the high half and their sum; after that one piece leaves per
// cycle while the receiver does not stall. When a translate spills into the
// next extent, its second span runs the divisions and multiply steps again.
// The last result sits in the output register while the next transaction
// is taken. A receiver stall holds the output register and the controller
// waits before each new result, so nothing is lost.
// After reset the extent memory is swept clear, one slot per cycle
// (DEVICES * FILES_PER_DEVICE * EXTENTS_PER_FILE slots, 2048 by default);
// o_stall stays high meanwhile. Configuration writes are taken at any time.
module extent_raid0_address_splitter_unit #(
    parameter int DEVICES          = eras_pkg::DEVICES_DEF,
    parameter int FILES_PER_DEVICE = eras_pkg::FILES_PER_DEVICE_DEF,
    parameter int EXTENTS_PER_FILE = eras_pkg::EXTENTS_PER_FILE_DEF,
    parameter int MAX_PIECES       = eras_pkg::MAX_PIECES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [eras_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [eras_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [eras_pkg::DEV_W-1:0]        i_device_index,
    input  logic [eras_pkg::FILE_W-1:0]       i_file_index,
    input  logic [eras_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic                              i_entry_valid,
    input  logic [eras_pkg::ADDR_W-1:0]       i_extent_logical,
    input  logic [eras_pkg::ADDR_W-1:0]       i_extent_physical,
    input  logic [eras_pkg::LEN_W-1:0]        i_extent_length,
    input  logic [eras_pkg::ADDR_W-1:0]       i_logical_offset,
    input  logic [eras_pkg::TAG_W-1:0]        i_request_tag,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [eras_pkg::DEV_W-1:0]        o_target_device,
    output logic [eras_pkg::ADDR_W-1:0]       o_device_offset,
    output logic [eras_pkg::PLEN_W-1:0]       o_piece_length,
    output logic [eras_pkg::TAG_W-1:0]        o_tag_out,
    output logic [eras_pkg::STAT_W-1:0]       o_status,
    output logic                              o_last
);

    eras_pkg::t_cmd cmd;
    eras_pkg::t_sts sts;

    // sequencer
    eras_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // memory and arithmetic
    eras_dp #(
        .DEVICES          (DEVICES),
        .FILES_PER_DEVICE (FILES_PER_DEVICE),
        .EXTENTS_PER_FILE (EXTENTS_PER_FILE),
        .MAX_PIECES       (MAX_PIECES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_device_index    (i_device_index),
        .i_file_index      (i_file_index),
        .i_entry_index     (i_entry_index),
        .i_entry_valid     (i_entry_valid),
        .i_extent_logical  (i_extent_logical),
        .i_extent_physical (i_extent_physical),
        .i_extent_length   (i_extent_length),
        .i_logical_offset  (i_logical_offset),
        .i_request_tag     (i_request_tag),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_target_device   (o_target_device),
        .o_device_offset   (o_device_offset),
        .o_piece_length    (o_piece_length),
        .o_tag_out         (o_tag_out),
        .o_status          (o_status),
        .o_last            (o_last)
    );

    // no transaction is taken while the memory is being cleared
    a_stall_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sts.clr_done |-> o_stall)
        else $error("transaction accepted during clearing pass");

    // a result is only loaded when the output register can take it
    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit != eras_pkg::EM_NONE) |-> (!o_valid || !i_stall))
        else $error("result overwrote a stalled output");

    // a write acknowledge always closes its run
    a_ack_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == eras_pkg::ST_WRITE_ACK)) |-> o_last)
        else $error("write acknowledge without last");

    // data pieces are never empty
    a_piece_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == eras_pkg::ST_OK) || (o_status == eras_pkg::ST_TRUNCATED)))
        |-> (o_piece_length != '0))
        else $error("empty piece emitted");

endmodule

[rtl/eras_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module eras_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [eras_pkg::START_W-1:0]    i_dividend,
    input  logic [eras_pkg::STRIPE_W-1:0]   i_divisor,
    output logic                            o_busy,
    output logic [eras_pkg::START_W-1:0]    o_quotient,
    output logic [eras_pkg::STRIPE_W-1:0]   o_remainder
);

    localparam int CNT_W = $clog2(eras_pkg::START_W + 1);

    logic [eras_pkg::STRIPE_W-1:0] r_divisor;
    logic [eras_pkg::START_W-1:0]  r_quo;
    logic [eras_pkg::STRIPE_W-1:0] r_rem;
    logic [CNT_W-1:0]              r_cnt;
    logic [eras_pkg::STRIPE_W:0]   trial;
    logic                          fits;

    // trial subtraction of the next bit
    always_comb begin
        trial = {r_rem, r_quo[eras_pkg::START_W-1]};
        fits  = trial >= {1'b0, r_divisor};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(eras_pkg::START_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_quo     <= i_dividend;
            r_rem     <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[eras_pkg::START_W-2:0], fits};
            if (fits) begin
                r_rem <= eras_pkg::STRIPE_W'(trial - {1'b0, r_divisor});
            end else begin
                r_rem <= trial[eras_pkg::STRIPE_W-1:0];
            end
        end
    end

    assign o_busy      = r_cnt != '0;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[rtl/eras_dp.sv]
// datapath: extent memory, configuration, span arithmetic and output register
module eras_dp #(
    parameter int DEVICES          = eras_pkg::DEVICES_DEF,
    parameter int FILES_PER_DEVICE = eras_pkg::FILES_PER_DEVICE_DEF,
    parameter int EXTENTS_PER_FILE = eras_pkg::EXTENTS_PER_FILE_DEF,
    parameter int MAX_PIECES       = eras_pkg::MAX_PIECES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  eras_pkg::t_cmd                    i_cmd,
    output eras_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [eras_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [eras_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_req_type,
    input  logic [eras_pkg::DEV_W-1:0]        i_device_index,
    input  logic [eras_pkg::FILE_W-1:0]       i_file_index,
    input  logic [eras_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic                              i_entry_valid,
    input  logic [eras_pkg::ADDR_W-1:0]       i_extent_logical,
    input  logic [eras_pkg::ADDR_W-1:0]       i_extent_physical,
    input  logic [eras_pkg::LEN_W-1:0]        i_extent_length,
    input  logic [eras_pkg::ADDR_W-1:0]       i_logical_offset,
    input  logic [eras_pkg::TAG_W-1:0]        i_request_tag,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [eras_pkg::DEV_W-1:0]        o_target_device,
    output logic [eras_pkg::ADDR_W-1:0]       o_device_offset,
    output logic [eras_pkg::PLEN_W-1:0]       o_piece_length,
    output logic [eras_pkg::TAG_W-1:0]        o_tag_out,
    output logic [eras_pkg::STAT_W-1:0]       o_status,
    output logic                              o_last
);

    localparam int SLOTS  = DEVICES * FILES_PER_DEVICE * EXTENTS_PER_FILE;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int KW     = $clog2(EXTENTS_PER_FILE);
    localparam int NW     = $clog2(MAX_PIECES + 1);
    localparam int ADDR_W = eras_pkg::ADDR_W;
    localparam int LEN_W  = eras_pkg::LEN_W;
    localparam int PLEN_W = eras_pkg::PLEN_W;
    localparam int START_W  = eras_pkg::START_W;
    localparam int STRIPE_W = eras_pkg::STRIPE_W;
    localparam int CHUNK_W  = eras_pkg::CHUNK_W;
    localparam int MEMB_W   = eras_pkg::MEMB_W;
    localparam int SPLIT    = eras_pkg::MUL_SPLIT;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] logical;
        logic [ADDR_W-1:0] physical;
        logic [LEN_W-1:0]  length;
    } t_entry;

    // configuration registers
    logic [eras_pkg::BS_W-1:0] r_block_size;
    logic [CHUNK_W-1:0]        r_chunk;
    logic [MEMB_W-1:0]         r_members;

    // captured transaction
    logic                          r_type;
    logic [eras_pkg::DEV_W-1:0]    r_dev;
    logic [eras_pkg::FILE_W-1:0]   r_file;
    logic [eras_pkg::ENTRY_W-1:0]  r_entry;
    logic                          r_ent_valid;
    logic [ADDR_W-1:0]             r_ext_log;
    logic [ADDR_W-1:0]             r_ext_phy;
    logic [LEN_W-1:0]              r_ext_len;
    logic [ADDR_W-1:0]             r_off;
    logic [eras_pkg::TAG_W-1:0]    r_tag;

    // extent memory and clearing pass
    t_entry            r_mem [SLOTS];
    t_entry            r_rd;
    logic [SLOT_W-1:0] r_clr_addr;
    logic              r_clr_done;

    // translate state
    logic [KW-1:0]       r_k;
    logic [NW-1:0]       r_n;
    logic                r_second;
    logic [ADDR_W-1:0]   r_rel;
    logic [ADDR_W-1:0]   r_hit_phy;
    logic [LEN_W-1:0]    r_hit_len;
    logic [LEN_W-1:0]    r_avail;
    logic [START_W-1:0]  r_start;
    logic [PLEN_W-1:0]   r_len;
    logic [PLEN_W-1:0]   r_rem2;
    logic [ADDR_W-1:0]   r_p2;
    logic [STRIPE_W-1:0] r_width;
    logic [START_W-1:0]  r_row;
    logic [STRIPE_W-1:0] r_in_stripe;
    logic [eras_pkg::DEV_W-1:0] r_pdev;
    logic [CHUNK_W-1:0]  r_in_chunk;
    logic [ADDR_W-1:0]   r_prod_lo;
    logic [ADDR_W-1:0]   r_prod_hi;
    logic [ADDR_W-1:0]   r_rowbase;

    // output register
    logic                       r_o_valid;
    logic [eras_pkg::DEV_W-1:0] r_o_dev;
    logic [ADDR_W-1:0]          r_o_off;
    logic [PLEN_W-1:0]          r_o_len;
    logic [eras_pkg::TAG_W-1:0] r_o_tag;
    eras_pkg::t_status          r_o_status;
    logic                       r_o_last;

    // combinational helpers
    logic                key_ok;
    logic                entry_ok;
    logic [SLOT_W-1:0]   wr_addr;
    logic [SLOT_W-1:0]   rd_addr;
    logic                hit;
    logic [PLEN_W-1:0]   rem_eff;
    logic                short_first;
    logic [MEMB_W-1:0]   members;
    logic [STRIPE_W:0]   width_full;
    logic                striped;
    logic [START_W-1:0]  div_dividend;
    logic [STRIPE_W-1:0] div_divisor;
    logic                div_busy;
    logic [START_W-1:0]  div_quo;
    logic [STRIPE_W-1:0] div_rem;
    logic [SPLIT-1:0]    mul_a;
    logic [2*SPLIT-1:0]  mul_p;
    logic [CHUNK_W-1:0]  chunk_left;
    logic [PLEN_W-1:0]   plen;
    logic [ADDR_W-1:0]   poff;
    logic [eras_pkg::DEV_W-1:0] pdev;
    logic                more_len;
    logic                more;
    logic                at_cap;
    logic                out_free;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [eras_pkg::DEV_W-1:0] dev,
                                                  input logic [eras_pkg::FILE_W-1:0] file,
                                                  input int e);
        return SLOT_W'((int'(dev) * FILES_PER_DEVICE + int'(file)) * EXTENTS_PER_FILE + e);
    endfunction

    // key checks and memory addresses
    always_comb begin
        key_ok   = (int'(r_dev) < DEVICES) && (int'(r_file) < FILES_PER_DEVICE);
        entry_ok = int'(r_entry) < EXTENTS_PER_FILE;
        wr_addr  = slot_of(r_dev, r_file, int'(r_entry));
        if (i_cmd.rd_next) begin
            rd_addr = slot_of(r_dev, r_file, int'(r_k) + 1);
        end else begin
            rd_addr = slot_of(r_dev, r_file, int'(r_k));
        end
    end

    // extent cover test on the read slot
    always_comb begin
        hit = r_rd.valid && (r_off >= r_rd.logical) &&
              ({1'b0, r_off} < ({1'b0, r_rd.logical} + (ADDR_W + 1)'(r_rd.length)));
    end

    // register corners and stripe width
    always_comb begin
        rem_eff     = (r_block_size == '0) ? PLEN_W'(1) : r_block_size;
        short_first = r_avail < LEN_W'(rem_eff);
        if (r_members == '0) begin
            members = MEMB_W'(1);
        end else if (r_members > MEMB_W'(eras_pkg::MEMB_MAX)) begin
            members = MEMB_W'(eras_pkg::MEMB_MAX);
        end else begin
            members = r_members;
        end
        width_full = (STRIPE_W + 1)'(r_chunk) * (STRIPE_W + 1)'(members);
        striped    = r_chunk != '0;
    end

    // divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            eras_pkg::DIV_ROW: begin
                div_dividend = r_start;
                div_divisor  = r_width;
            end
            eras_pkg::DIV_CHUNK: begin
                div_dividend = START_W'(r_in_stripe);
                div_divisor  = STRIPE_W'(r_chunk);
            end
        endcase
    end

    eras_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // shared multiplier for row times chunk, one half per cycle
    always_comb begin
        if (i_cmd.mul_hi) begin
            mul_a = SPLIT'(r_row[START_W-1:SPLIT]);
        end else begin
            mul_a = r_row[SPLIT-1:0];
        end
        mul_p = (2*SPLIT)'(mul_a) * (2*SPLIT)'(r_chunk);
    end

    // current piece
    always_comb begin
        chunk_left = r_chunk - r_in_chunk;
        if (striped && (r_len > PLEN_W'(chunk_left))) begin
            plen = PLEN_W'(chunk_left);
        end else begin
            plen = r_len;
        end
        if (striped) begin
            poff = r_rowbase + ADDR_W'(r_in_chunk);
            pdev = r_pdev;
        end else begin
            poff = r_start[ADDR_W-1:0];
            pdev = r_dev;
        end
        more_len = r_len != plen;
        more     = more_len || r_second;
        at_cap   = (int'(r_n) + 1) == MAX_PIECES;
        out_free = !r_o_valid || !i_stall;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= eras_pkg::BLOCK_SIZE_RST;
            r_chunk      <= eras_pkg::CHUNK_RST;
            r_members    <= eras_pkg::MEMBERS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eras_pkg::CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[eras_pkg::BS_W-1:0];
                eras_pkg::CFG_CHUNK_SIZE: r_chunk      <= i_cfg_data[CHUNK_W-1:0];
                eras_pkg::CFG_MEMBERS:    r_members    <= i_cfg_data[MEMB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type      <= i_req_type;
            r_dev       <= i_device_index;
            r_file      <= i_file_index;
            r_entry     <= i_entry_index;
            r_ent_valid <= i_entry_valid;
            r_ext_log   <= i_extent_logical;
            r_ext_phy   <= i_extent_physical;
            r_ext_len   <= i_extent_length;
            r_off       <= i_logical_offset;
            r_tag       <= i_request_tag;
        end
    end

    // clearing pass over the extent memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clr && !r_clr_done) begin
            if (int'(r_clr_addr) == SLOTS - 1) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // extent memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.mem_wr && key_ok && entry_ok) begin
            r_mem[wr_addr] <= '{valid: r_ent_valid, logical: r_ext_log,
                                physical: r_ext_phy, length: r_ext_len};
        end
    end

    // extent memory read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_scan || i_cmd.rd_next) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // slot and piece counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_n <= '0;
        end else if (i_cmd.capture) begin
            r_k <= '0;
            r_n <= '0;
        end else begin
            if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.emit == eras_pkg::EM_PIECE) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    // first extent arithmetic and span start
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_load) begin
            r_rel     <= r_off - r_rd.logical;
            r_hit_phy <= r_rd.physical;
            r_hit_len <= r_rd.length;
        end
        if (i_cmd.calc_a) begin
            r_avail <= r_hit_len - r_rel[LEN_W-1:0];
            r_start <= START_W'(r_hit_phy) + START_W'(r_rel);
        end else if (i_cmd.span2_load) begin
            r_start <= START_W'(r_p2);
        end
        if (i_cmd.p2_load) begin
            r_p2 <= r_rd.physical;
        end
    end

    // span length and second span flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_second <= 1'b0;
        end else if (i_cmd.calc_b) begin
            r_second <= short_first;
            if (short_first) begin
                r_len  <= r_avail[PLEN_W-1:0];
                r_rem2 <= rem_eff - r_avail[PLEN_W-1:0];
            end else begin
                r_len  <= rem_eff;
                r_rem2 <= '0;
            end
        end else if (i_cmd.span2_load) begin
            r_second <= 1'b0;
            r_len    <= r_rem2;
        end else if (i_cmd.emit == eras_pkg::EM_PIECE) begin
            r_len <= r_len - plen;
        end
    end

    // stripe position: width, divisions, row base and member walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.width_load) begin
            r_width <= width_full[STRIPE_W-1:0];
        end
        if (i_cmd.div_row_save) begin
            r_row       <= div_quo;
            r_in_stripe <= div_rem;
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= mul_p[ADDR_W-1:0];
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= mul_p[ADDR_W-1:0];
        end
        if (i_cmd.div_chunk_save) begin
            r_pdev     <= div_quo[eras_pkg::DEV_W-1:0];
            r_in_chunk <= div_rem[CHUNK_W-1:0];
        end else if (i_cmd.emit == eras_pkg::EM_PIECE && striped) begin
            r_in_chunk <= '0;
            if ((MEMB_W'(r_pdev) + 1'b1) == members) begin
                r_pdev <= '0;
            end else begin
                r_pdev <= r_pdev + 1'b1;
            end
        end
        if (i_cmd.mul_sum) begin
            r_rowbase <= r_prod_lo + {r_prod_hi[ADDR_W-SPLIT-1:0], {SPLIT{1'b0}}};
        end else if (i_cmd.emit == eras_pkg::EM_PIECE && striped &&
                     ((MEMB_W'(r_pdev) + 1'b1) == members)) begin
            r_rowbase <= r_rowbase + ADDR_W'(r_chunk);
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit != eras_pkg::EM_NONE) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != eras_pkg::EM_NONE) begin
            r_o_tag <= r_tag;
        end
        unique case (i_cmd.emit)
            eras_pkg::EM_NONE: begin
            end
            eras_pkg::EM_ACK: begin
                r_o_dev    <= '0;
                r_o_off    <= '0;
                r_o_len    <= '0;
                r_o_status <= eras_pkg::ST_WRITE_ACK;
                r_o_last   <= 1'b1;
            end
            eras_pkg::EM_NOT_FOUND: begin
                r_o_dev    <= '0;
                r_o_off    <= '0;
                r_o_len    <= '0;
                r_o_status <= eras_pkg::ST_NOT_FOUND;
                r_o_last   <= 1'b1;
            end
            eras_pkg::EM_PAST: begin
                r_o_dev    <= '0;
                r_o_off    <= '0;
                r_o_len    <= '0;
                r_o_status <= eras_pkg::ST_PAST_END;
                r_o_last   <= 1'b1;
            end
            eras_pkg::EM_PIECE: begin
                r_o_dev    <= pdev;
                r_o_off    <= poff;
                r_o_len    <= plen;
                r_o_status <= (more && at_cap) ? eras_pkg::ST_TRUNCATED : eras_pkg::ST_OK;
                r_o_last   <= !more || at_cap;
            end
            default: begin
            end
        endcase
    end

    // status to the controller
    always_comb begin
        o_sts.clr_done    = r_clr_done;
        o_sts.is_write    = r_type == eras_pkg::REQ_WRITE;
        o_sts.key_ok      = key_ok;
        o_sts.k_last      = int'(r_k) == EXTENTS_PER_FILE - 1;
        o_sts.hit         = hit;
        o_sts.rem_left    = r_second;
        o_sts.next_exists = (int'(r_k) + 1) < EXTENTS_PER_FILE;
        o_sts.rd_valid    = r_rd.valid;
        o_sts.striped     = striped;
        o_sts.div_busy    = div_busy;
        o_sts.out_free    = out_free;
        o_sts.piece_final = !more || at_cap;
        o_sts.piece_more  = more_len;
    end

    assign o_valid         = r_o_valid;
    assign o_target_device = r_o_dev;
    assign o_device_offset = r_o_off;
    assign o_piece_length  = r_o_len;
    assign o_tag_out       = r_o_tag;
    assign o_status        = r_o_status;
    assign o_last          = r_o_last;

endmodule

[rtl/eras_ctrl.sv]
// controller: sequences clearing, extent writes, slot scan and piece emission
module eras_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  eras_pkg::t_sts i_sts,
    output eras_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_ACK,
        S_NOT_FOUND,
        S_PAST,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CALC_A,
        S_CALC_B,
        S_SPLIT,
        S_NEXT_RD,
        S_NEXT_CHK,
        S_SPAN,
        S_DIV_ROW,
        S_ROW_WAIT,
        S_DIV_CHUNK,
        S_CHUNK_WAIT,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_PIECE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_write) n_state = S_WRITE;
                else if (!i_sts.key_ok) n_state = S_NOT_FOUND;
                else n_state = S_SCAN_RD;
            end
            S_WRITE: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_ACK;
            end
            S_ACK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = eras_pkg::EM_ACK;
                    n_state    = S_IDLE;
                end
            end
            S_NOT_FOUND: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = eras_pkg::EM_NOT_FOUND;
                    n_state    = S_IDLE;
                end
            end
            S_PAST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = eras_pkg::EM_PAST;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.hit_load = 1'b1;
                    n_state        = S_CALC_A;
                end else if (i_sts.k_last) begin
                    n_state = S_NOT_FOUND;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end
            S_CALC_A: begin
                o_cmd.calc_a = 1'b1;
                n_state      = S_CALC_B;
            end
            S_CALC_B: begin
                o_cmd.calc_b = 1'b1;
                n_state      = S_SPLIT;
            end
            S_SPLIT: begin
                if (!i_sts.rem_left) n_state = S_SPAN;
                else if (i_sts.next_exists) n_state = S_NEXT_RD;
                else n_state = S_PAST;
            end
            S_NEXT_RD: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_NEXT_CHK;
            end
            S_NEXT_CHK: begin
                if (i_sts.rd_valid) begin
                    o_cmd.p2_load = 1'b1;
                    n_state       = S_SPAN;
                end else begin
                    n_state = S_PAST;
                end
            end
            S_SPAN: begin
                if (i_sts.striped) begin
                    o_cmd.width_load = 1'b1;
                    n_state          = S_DIV_ROW;
                end else begin
                    n_state = S_PIECE;
                end
            end
            S_DIV_ROW: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = eras_pkg::DIV_ROW;
                n_state         = S_ROW_WAIT;
            end
            S_ROW_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_row_save = 1'b1;
                    n_state            = S_DIV_CHUNK;
                end
            end
            S_DIV_CHUNK: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = eras_pkg::DIV_CHUNK;
                n_state         = S_CHUNK_WAIT;
            end
            S_CHUNK_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_chunk_save = 1'b1;
                    n_state              = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MUL_SUM;
            end
            S_MUL_SUM: begin
                o_cmd.mul_sum = 1'b1;
                n_state       = S_PIECE;
            end
            S_PIECE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = eras_pkg::EM_PIECE;
                    if (i_sts.piece_final) begin
                        n_state = S_IDLE;
                    end else if (!i_sts.piece_more) begin
                        o_cmd.span2_load = 1'b1;
                        n_state          = S_SPAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and input stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= n_state != S_IDLE;
        end
    end

    assign o_stall = r_stall;

endmodule
